/* hdl/assert_macros.svh */
// Assertion helpers shared by the RTL; clk and rst are the block's clock and reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while in reset.
`define RHS_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Implication after a fixed number of cycles, off while in reset.
`define RHS_ASSERT_DELAY(lbl, ante, n, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##n (cons)) \
    else $error(msg);

`endif

/* hdl/rhs_pkg.sv */
package rhs_pkg;

  // Field widths
  localparam int unsigned COL_W    = 10;
  localparam int unsigned SIDE_W   = 11;
  localparam int unsigned POS_FRAC = 8;
  localparam int unsigned POS_W    = COL_W + POS_FRAC;
  localparam int unsigned RAD_W    = 16;
  localparam int unsigned STR_W    = 23;
  localparam int unsigned HGT_W    = 24;
  localparam int unsigned MODE_W   = 2;
  localparam int unsigned IDX_W    = 3;
  localparam int unsigned CFG_W    = 24;

  // Internal widths
  localparam int unsigned OPND_W = HGT_W + 1;
  localparam int unsigned R2_W   = 2 * RAD_W;
  localparam int unsigned QUO_W  = R2_W + 1;
  localparam int unsigned ROOT_W = R2_W / 2 + 1;
  localparam int unsigned HALF_W = ROOT_W - 1;
  localparam int unsigned F_W    = HALF_W + 1;
  localparam int unsigned W_W    = HALF_W + 2;

  // Pipeline depth per section
  localparam int unsigned FRONT_STAGES = 3;
  localparam int unsigned DIV_STAGES   = QUO_W;
  localparam int unsigned SQRT_STAGES  = ROOT_W;
  localparam int unsigned FALL_STAGES  = 3;
  localparam int unsigned APPLY_STAGES = 3;
  localparam int unsigned PIPE_DEPTH   = FRONT_STAGES + DIV_STAGES + SQRT_STAGES
                                         + FALL_STAGES + APPLY_STAGES;

  // Constants
  localparam logic [RAD_W-1:0]  RADIUS_RESET = RAD_W'(256);
  localparam logic [SIDE_W-1:0] SIDE_RESET   = SIDE_W'(1024);
  localparam logic [F_W-1:0]    ONE_Q16      = F_W'(65536);
  localparam logic [W_W-1:0]    SMOOTH_K     = W_W'(3 * 65536);

  typedef enum logic [MODE_W-1:0] {
    MODE_FLATTEN = 2'd0,
    MODE_CRATER  = 2'd1,
    MODE_HILL    = 2'd2,
    MODE_HOLD    = 2'd3
  } mode_t;

  typedef enum logic [IDX_W-1:0] {
    REG_MODE     = 3'd0,
    REG_CCOL     = 3'd1,
    REG_CROW     = 3'd2,
    REG_RADIUS   = 3'd3,
    REG_STRENGTH = 3'd4,
    REG_CHEIGHT  = 3'd5,
    REG_SIDE     = 3'd6
  } reg_idx_t;

  // Per-vertex data that rides along the pipeline
  typedef struct packed {
    logic                     hit;
    logic signed [HGT_W-1:0]  cur;
    logic signed [OPND_W-1:0] opnd;
  } item_t;

  // Brush setup seen by the pipeline
  typedef struct packed {
    mode_t                   mode;
    logic [POS_W-1:0]        ccol;
    logic [POS_W-1:0]        crow;
    logic [STR_W-1:0]        strength;
    logic signed [HGT_W-1:0] cheight;
    logic [SIDE_W-1:0]       side;
    logic [R2_W-1:0]         r2;
  } cfg_t;

endpackage

/* hdl/rhs_front.sv */
module rhs_front (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_vld,
  input  logic [rhs_pkg::COL_W-1:0]         col,
  input  logic [rhs_pkg::COL_W-1:0]         row,
  input  logic signed [rhs_pkg::HGT_W-1:0]  cur,
  input  rhs_pkg::cfg_t                     cfg,
  output logic                              out_vld,
  output rhs_pkg::item_t                    item,
  output logic [rhs_pkg::R2_W-1:0]          rem
);

  localparam int unsigned SQ_W = 2 * rhs_pkg::POS_W;

  logic                              vld1, vld2;
  logic signed [rhs_pkg::POS_W:0]    dx, dy;
  logic                              grid1, grid2;
  logic signed [rhs_pkg::HGT_W-1:0]  cur1, cur2;
  logic signed [rhs_pkg::OPND_W-1:0] opnd1, opnd2;
  logic [SQ_W-1:0]                   sqx, sqy;
  logic signed [SQ_W+1:0]            px_c, py_c;
  logic [SQ_W:0]                     d2_c;
  logic                              hit_c;

  // Valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      vld1    <= 1'b0;
      vld2    <= 1'b0;
      out_vld <= 1'b0;
    end else begin
      vld1    <= in_vld;
      vld2    <= vld1;
      out_vld <= vld2;
    end
  end

  // Stage 1: offsets from the centre, grid test, blend operand
  always_ff @(posedge clk) begin
    dx    <= $signed({1'b0, col, {rhs_pkg::POS_FRAC{1'b0}}}) - $signed({1'b0, cfg.ccol});
    dy    <= $signed({1'b0, row, {rhs_pkg::POS_FRAC{1'b0}}}) - $signed({1'b0, cfg.crow});
    // column and row never reach 1024, so comparing to the raw side covers the clamp
    grid1 <= (rhs_pkg::SIDE_W'(col) < cfg.side) && (rhs_pkg::SIDE_W'(row) < cfg.side);
    cur1  <= cur;
    if (cfg.mode == rhs_pkg::MODE_FLATTEN) begin
      opnd1 <= {cfg.cheight[rhs_pkg::HGT_W-1], cfg.cheight} - {cur[rhs_pkg::HGT_W-1], cur};
    end else begin
      opnd1 <= {2'b00, cfg.strength};
    end
  end

  // Stage 2: squares
  assign px_c = dx * dx;
  assign py_c = dy * dy;

  always_ff @(posedge clk) begin
    sqx   <= px_c[SQ_W-1:0];
    sqy   <= py_c[SQ_W-1:0];
    grid2 <= grid1;
    cur2  <= cur1;
    opnd2 <= opnd1;
  end

  // Stage 3: squared distance against squared radius
  assign d2_c  = {1'b0, sqx} + {1'b0, sqy};
  assign hit_c = grid2 && (d2_c <= (SQ_W + 1)'(cfg.r2));

  always_ff @(posedge clk) begin
    item.hit  <= hit_c;
    item.cur  <= cur2;
    item.opnd <= opnd2;
    // park outside vertices at zero so the divider stays in range
    rem       <= hit_c ? d2_c[rhs_pkg::R2_W-1:0] : '0;
  end

endmodule

/* hdl/rhs_divider.sv */
module rhs_divider (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_vld,
  input  rhs_pkg::item_t               item_in,
  input  logic [rhs_pkg::R2_W-1:0]     rem_in,
  input  logic [rhs_pkg::R2_W-1:0]     r2,
  output logic                         out_vld,
  output rhs_pkg::item_t               item_out,
  output logic [rhs_pkg::QUO_W-1:0]    quo
);

  localparam int unsigned N = rhs_pkg::DIV_STAGES;

  logic                        vld_q  [N];
  logic [rhs_pkg::R2_W-1:0]    rem_q  [N];
  logic [rhs_pkg::QUO_W-1:0]   quo_q  [N];
  rhs_pkg::item_t              item_q [N];

  // One quotient bit per stage, most significant first
  for (genvar k = 0; k < N; k++) begin : g_step
    logic                       vld_prev;
    logic [rhs_pkg::R2_W-1:0]   rem_prev;
    logic [rhs_pkg::QUO_W-1:0]  quo_prev;
    rhs_pkg::item_t             item_prev;
    logic [rhs_pkg::R2_W:0]     part;
    logic [rhs_pkg::R2_W:0]     diff;
    logic                       take;

    if (k == 0) begin : g_first
      assign vld_prev  = in_vld;
      assign rem_prev  = rem_in;
      assign quo_prev  = '0;
      assign item_prev = item_in;
      // integer bit: the dividend never exceeds the divisor
      assign part      = {1'b0, rem_prev};
    end else begin : g_rest
      assign vld_prev  = vld_q[k-1];
      assign rem_prev  = rem_q[k-1];
      assign quo_prev  = quo_q[k-1];
      assign item_prev = item_q[k-1];
      assign part      = {rem_prev, 1'b0};
    end

    assign diff = part - {1'b0, r2};
    assign take = part >= {1'b0, r2};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q[k] <= 1'b0;
      end else begin
        vld_q[k] <= vld_prev;
      end
    end

    always_ff @(posedge clk) begin
      rem_q[k]  <= take ? diff[rhs_pkg::R2_W-1:0] : part[rhs_pkg::R2_W-1:0];
      quo_q[k]  <= {quo_prev[rhs_pkg::QUO_W-2:0], take};
      item_q[k] <= item_prev;
    end
  end

  assign out_vld  = vld_q[N-1];
  assign item_out = item_q[N-1];
  assign quo      = quo_q[N-1];

endmodule

/* hdl/rhs_sqrt.sv */
module rhs_sqrt (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_vld,
  input  rhs_pkg::item_t               item_in,
  input  logic [rhs_pkg::QUO_W-1:0]    quo_in,
  output logic                         out_vld,
  output rhs_pkg::item_t               item_out,
  output logic [rhs_pkg::ROOT_W-1:0]   root
);

  localparam int unsigned N    = rhs_pkg::SQRT_STAGES;
  localparam int unsigned RS_W = rhs_pkg::QUO_W + 1;

  logic                         vld_q  [N];
  logic [RS_W-1:0]              rem_q  [N];
  logic [rhs_pkg::ROOT_W-1:0]   root_q [N];
  rhs_pkg::item_t               item_q [N];

  // One root bit per stage; the remainder holds radicand minus root squared
  for (genvar k = 0; k < N; k++) begin : g_step
    localparam int unsigned I = rhs_pkg::ROOT_W - 1 - k;

    logic                        vld_prev;
    logic [RS_W-1:0]             rem_prev;
    logic [rhs_pkg::ROOT_W-1:0]  root_prev;
    rhs_pkg::item_t              item_prev;
    logic [RS_W-1:0]             trial;
    logic                        take;

    if (k == 0) begin : g_first
      assign vld_prev  = in_vld;
      assign rem_prev  = RS_W'(quo_in);
      assign root_prev = '0;
      assign item_prev = item_in;
    end else begin : g_rest
      assign vld_prev  = vld_q[k-1];
      assign rem_prev  = rem_q[k-1];
      assign root_prev = root_q[k-1];
      assign item_prev = item_q[k-1];
    end

    // (root + 2^I)^2 - root^2
    assign trial = (RS_W'(root_prev) << (I + 1)) + (RS_W'(1) << (2 * I));
    assign take  = rem_prev >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q[k] <= 1'b0;
      end else begin
        vld_q[k] <= vld_prev;
      end
    end

    always_ff @(posedge clk) begin
      rem_q[k]  <= take ? rem_prev - trial : rem_prev;
      root_q[k] <= take ? (root_prev | (rhs_pkg::ROOT_W'(1) << I)) : root_prev;
      item_q[k] <= item_prev;
    end
  end

  assign out_vld  = vld_q[N-1];
  assign item_out = item_q[N-1];
  assign root     = root_q[N-1];

endmodule

/* hdl/rhs_falloff.sv */
module rhs_falloff (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_vld,
  input  rhs_pkg::item_t               item_in,
  input  logic [rhs_pkg::ROOT_W-1:0]   root,
  output logic                         out_vld,
  output rhs_pkg::item_t               item_out,
  output logic [rhs_pkg::F_W-1:0]      f
);

  localparam int unsigned TSQ_W = 2 * rhs_pkg::HALF_W;
  localparam int unsigned S_W   = TSQ_W + rhs_pkg::W_W;

  logic                          vld1, vld2;
  rhs_pkg::item_t                item1, item2;
  logic [TSQ_W-1:0]              tsq;
  logic [rhs_pkg::W_W-1:0]       wgt;
  logic                          full1, full2;
  logic [S_W-1:0]                s_c;
  logic [rhs_pkg::HALF_W-1:0]    s_hi;

  // Valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      vld1    <= 1'b0;
      vld2    <= 1'b0;
      out_vld <= 1'b0;
    end else begin
      vld1    <= in_vld;
      vld2    <= vld1;
      out_vld <= vld2;
    end
  end

  // Stage 1: t^2 in Q32 and (3 - 2t) in Q16
  always_ff @(posedge clk) begin
    tsq   <= root[rhs_pkg::HALF_W-1:0] * root[rhs_pkg::HALF_W-1:0];
    wgt   <= rhs_pkg::SMOOTH_K - {1'b0, root[rhs_pkg::HALF_W-1:0], 1'b0};
    full1 <= root[rhs_pkg::HALF_W];
    item1 <= item_in;
  end

  // Stage 2: smoothstep in Q48, keep the Q16 part
  assign s_c = tsq * wgt;

  always_ff @(posedge clk) begin
    s_hi  <= s_c[TSQ_W +: rhs_pkg::HALF_W];
    full2 <= full1;
    item2 <= item1;
  end

  // Stage 3: weight is one minus smoothstep, zero on the rim
  always_ff @(posedge clk) begin
    f        <= full2 ? '0 : rhs_pkg::ONE_Q16 - {1'b0, s_hi};
    item_out <= item2;
  end

endmodule

/* hdl/rhs_apply.sv */
module rhs_apply (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_vld,
  input  rhs_pkg::item_t                    item_in,
  input  logic [rhs_pkg::F_W-1:0]           f,
  input  rhs_pkg::mode_t                    mode,
  output logic                              done,
  output logic signed [rhs_pkg::HGT_W-1:0]  new_height,
  output logic                              changed
);

  localparam int unsigned P_W   = rhs_pkg::OPND_W + rhs_pkg::F_W + 1;
  localparam int unsigned FB    = rhs_pkg::HALF_W;
  localparam int unsigned RND_W = P_W - FB;
  localparam int unsigned NV_W  = RND_W + 1;
  localparam logic signed [P_W-1:0]  ROUND_HALF = P_W'(1) << (FB - 1);
  localparam logic signed [NV_W-1:0] HGT_MAX    = NV_W'((1 << (rhs_pkg::HGT_W - 1)) - 1);
  localparam logic signed [NV_W-1:0] HGT_MIN    = -NV_W'(1 << (rhs_pkg::HGT_W - 1));

  logic                       vld1, vld2;
  rhs_pkg::item_t             item1, item2;
  logic signed [P_W-1:0]      p_c, p;
  logic signed [P_W-1:0]      psum_c;
  logic signed [RND_W-1:0]    rnd;
  logic signed [NV_W-1:0]     cur_ext, rnd_ext, nv_c;
  logic signed [rhs_pkg::HGT_W-1:0] sat_c;

  // Valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      vld1    <= 1'b0;
      vld2    <= 1'b0;
      done    <= 1'b0;
      changed <= 1'b0;
    end else begin
      vld1    <= in_vld;
      vld2    <= vld1;
      done    <= vld2;
      changed <= vld2 && item2.hit;
    end
  end

  // Stage 1: scale the operand by the weight
  assign p_c = item_in.opnd * $signed({1'b0, f});

  always_ff @(posedge clk) begin
    p     <= p_c;
    item1 <= item_in;
  end

  // Stage 2: round to whole units, halves go up
  assign psum_c = p + ROUND_HALF;

  always_ff @(posedge clk) begin
    rnd   <= psum_c[P_W-1:FB];
    item2 <= item1;
  end

  // Stage 3: apply by mode and saturate
  assign cur_ext = NV_W'(item2.cur);
  assign rnd_ext = NV_W'(rnd);

  always_comb begin
    unique case (mode) inside
      rhs_pkg::MODE_FLATTEN, rhs_pkg::MODE_HILL: nv_c = cur_ext + rnd_ext;
      rhs_pkg::MODE_CRATER:                      nv_c = cur_ext - rnd_ext;
      default:                                   nv_c = cur_ext;
    endcase
  end

  always_comb begin
    if (nv_c > HGT_MAX) begin
      sat_c = HGT_MAX[rhs_pkg::HGT_W-1:0];
    end else if (nv_c < HGT_MIN) begin
      sat_c = HGT_MIN[rhs_pkg::HGT_W-1:0];
    end else begin
      sat_c = nv_c[rhs_pkg::HGT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    new_height <= item2.hit ? sat_c : item2.cur;
  end

endmodule

/* hdl/radial_height_stamp_top.sv */
// Radial height stamp: takes one heightmap vertex per clock and returns its stamped
// height. A vertex is taken when start is high and busy is low; busy is high only in
// reset and the cycle after it. Its result appears on new_height and changed once it
// has passed through every pipeline stage, marked by done for one cycle; there is no way
// to hold it off, so the receiver must take every done word. Up to 59 vertices are in flight
// and results come back in order. The latency is set mostly by the 33-stage
// distance-over-radius divider and the 17-stage square root that follow the
// distance squaring. Brush registers go through wr_en / wr_index / wr_data and must
// only change while no vertex is in flight; an index beyond the register list is
// ignored.
`include "assert_macros.svh"

module radial_height_stamp_top (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic [rhs_pkg::COL_W-1:0]         vertex_column,
  input  logic [rhs_pkg::COL_W-1:0]         vertex_row,
  input  logic signed [rhs_pkg::HGT_W-1:0]  current_height,
  output logic                              done,
  output logic signed [rhs_pkg::HGT_W-1:0]  new_height,
  output logic                              changed,
  input  logic                              wr_en,
  input  logic [rhs_pkg::IDX_W-1:0]         wr_index,
  input  logic [rhs_pkg::CFG_W-1:0]         wr_data
);

  localparam int unsigned LAT = rhs_pkg::PIPE_DEPTH;

  rhs_pkg::mode_t                   cfg_mode;
  logic [rhs_pkg::POS_W-1:0]        cfg_ccol;
  logic [rhs_pkg::POS_W-1:0]        cfg_crow;
  logic [rhs_pkg::RAD_W-1:0]        cfg_radius;
  logic [rhs_pkg::STR_W-1:0]        cfg_strength;
  logic signed [rhs_pkg::HGT_W-1:0] cfg_cheight;
  logic [rhs_pkg::SIDE_W-1:0]       cfg_side;
  logic [rhs_pkg::R2_W-1:0]         r2;
  logic [rhs_pkg::RAD_W-1:0]        r_eff;
  rhs_pkg::cfg_t                    cfg;

  logic                             accept;
  logic                             front_vld, div_vld, sqrt_vld, fall_vld;
  rhs_pkg::item_t                   front_item, div_item, sqrt_item, fall_item;
  logic [rhs_pkg::R2_W-1:0]         front_rem;
  logic [rhs_pkg::QUO_W-1:0]        div_quo;
  logic [rhs_pkg::ROOT_W-1:0]       sqrt_root;
  logic [rhs_pkg::F_W-1:0]          fall_f;

  // Hold off input only around reset
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b1;
    end else begin
      busy <= 1'b0;
    end
  end

  assign accept = start && !busy;

  // Brush register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_mode     <= rhs_pkg::MODE_FLATTEN;
      cfg_ccol     <= '0;
      cfg_crow     <= '0;
      cfg_radius   <= rhs_pkg::RADIUS_RESET;
      cfg_strength <= '0;
      cfg_cheight  <= '0;
      cfg_side     <= rhs_pkg::SIDE_RESET;
    end else if (wr_en) begin
      unique case (rhs_pkg::reg_idx_t'(wr_index))
        rhs_pkg::REG_MODE:     cfg_mode     <= rhs_pkg::mode_t'(wr_data[rhs_pkg::MODE_W-1:0]);
        rhs_pkg::REG_CCOL:     cfg_ccol     <= wr_data[rhs_pkg::POS_W-1:0];
        rhs_pkg::REG_CROW:     cfg_crow     <= wr_data[rhs_pkg::POS_W-1:0];
        rhs_pkg::REG_RADIUS:   cfg_radius   <= wr_data[rhs_pkg::RAD_W-1:0];
        rhs_pkg::REG_STRENGTH: cfg_strength <= wr_data[rhs_pkg::STR_W-1:0];
        rhs_pkg::REG_CHEIGHT:  cfg_cheight  <= wr_data[rhs_pkg::HGT_W-1:0];
        rhs_pkg::REG_SIDE:     cfg_side     <= wr_data[rhs_pkg::SIDE_W-1:0];
        default: ;
      endcase
    end
  end

  // Squared radius, a zero radius counts as one
  assign r_eff = (cfg_radius == '0) ? rhs_pkg::RAD_W'(1) : cfg_radius;

  always_ff @(posedge clk) begin
    r2 <= r_eff * r_eff;
  end

  assign cfg = '{
    mode:     cfg_mode,
    ccol:     cfg_ccol,
    crow:     cfg_crow,
    strength: cfg_strength,
    cheight:  cfg_cheight,
    side:     cfg_side,
    r2:       r2
  };

  rhs_front u_front (
    .clk     (clk),
    .rst     (rst),
    .in_vld  (accept),
    .col     (vertex_column),
    .row     (vertex_row),
    .cur     (current_height),
    .cfg     (cfg),
    .out_vld (front_vld),
    .item    (front_item),
    .rem     (front_rem)
  );

  rhs_divider u_divider (
    .clk      (clk),
    .rst      (rst),
    .in_vld   (front_vld),
    .item_in  (front_item),
    .rem_in   (front_rem),
    .r2       (r2),
    .out_vld  (div_vld),
    .item_out (div_item),
    .quo      (div_quo)
  );

  rhs_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .in_vld   (div_vld),
    .item_in  (div_item),
    .quo_in   (div_quo),
    .out_vld  (sqrt_vld),
    .item_out (sqrt_item),
    .root     (sqrt_root)
  );

  rhs_falloff u_falloff (
    .clk      (clk),
    .rst      (rst),
    .in_vld   (sqrt_vld),
    .item_in  (sqrt_item),
    .root     (sqrt_root),
    .out_vld  (fall_vld),
    .item_out (fall_item),
    .f        (fall_f)
  );

  rhs_apply u_apply (
    .clk        (clk),
    .rst        (rst),
    .in_vld     (fall_vld),
    .item_in    (fall_item),
    .f          (fall_f),
    .mode       (cfg_mode),
    .done       (done),
    .new_height (new_height),
    .changed    (changed)
  );

  // Checks
  `RHS_ASSERT_DELAY(a_fixed_latency, accept, LAT, done, "result word missing at fixed latency")
  `RHS_ASSERT_SAME(a_changed_strobed, changed, done, "changed set without a result word")
  `RHS_ASSERT_SAME(a_pass_through, done && !changed, new_height == $past(current_height, LAT), "untouched vertex height altered")

endmodule

/* tb/testbench.sv */
module testbench;

  localparam int      MAX_SIDE       = 1024;
  localparam longint  H_MAX          = 8388607;
  localparam longint  H_MIN          = -8388608;
  localparam int      STR_MAX        = 8388607;
  localparam int      RAD_MAX        = 65535;
  localparam int      WATCHDOG_LIMIT = 2000;
  localparam int      RANDOM_PHASES  = 12;
  localparam int      PHASE_VERTICES = 112;
  localparam logic [rhs_pkg::IDX_W-1:0] REG_UNUSED = 3'd7;

  typedef struct packed {
    logic [rhs_pkg::COL_W-1:0]        col;
    logic [rhs_pkg::COL_W-1:0]        row;
    logic signed [rhs_pkg::HGT_W-1:0] height;
  } vertex_t;

  typedef struct packed {
    logic signed [rhs_pkg::HGT_W-1:0] height;
    logic                             changed;
  } stamp_t;

  logic                             clk            = 1'b0;
  logic                             rst            = 1'b1;
  logic                             start          = 1'b0;
  logic                             busy;
  logic [rhs_pkg::COL_W-1:0]        vertex_column  = '0;
  logic [rhs_pkg::COL_W-1:0]        vertex_row     = '0;
  logic signed [rhs_pkg::HGT_W-1:0] current_height = '0;
  logic                             done;
  logic signed [rhs_pkg::HGT_W-1:0] new_height;
  logic                             changed;
  logic                             wr_en          = 1'b0;
  logic [rhs_pkg::IDX_W-1:0]        wr_index       = '0;
  logic [rhs_pkg::CFG_W-1:0]        wr_data        = '0;

  radial_height_stamp_top u_top (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .vertex_column  (vertex_column),
    .vertex_row     (vertex_row),
    .current_height (current_height),
    .done           (done),
    .new_height     (new_height),
    .changed        (changed),
    .wr_en          (wr_en),
    .wr_index       (wr_index),
    .wr_data        (wr_data)
  );

  always #2 clk = ~clk;

  // Brush setup as the block should see it
  rhs_pkg::mode_t                   brush_mode     = rhs_pkg::MODE_FLATTEN;
  logic [rhs_pkg::POS_W-1:0]        ctr_col        = '0;
  logic [rhs_pkg::POS_W-1:0]        ctr_row        = '0;
  logic [rhs_pkg::RAD_W-1:0]        brush_radius   = rhs_pkg::RADIUS_RESET;
  logic [rhs_pkg::STR_W-1:0]        brush_strength = '0;
  logic signed [rhs_pkg::HGT_W-1:0] ctr_height     = '0;
  logic [rhs_pkg::SIDE_W-1:0]       brush_side     = rhs_pkg::SIDE_RESET;

  vertex_t vertices_waiting[$];
  stamp_t  heights_due[$];

  int pushed_total   = 0;
  int vertices_taken = 0;
  int results_seen   = 0;
  int inside_seen    = 0;
  int settings_used  = 0;
  int errors         = 0;
  int idle_cycles    = 0;
  int burst_left     = 0;
  int gap_left       = 0;
  vertex_t vtx_on_port;

  // Round a Q16 product to the nearest integer, ties upward
  function automatic longint round_q16(longint p);
    return (p + 32768) >>> 16;
  endfunction

  // Stamped height of one vertex under the current brush
  function automatic stamp_t stamp_vertex(vertex_t v);
    longint unsigned eff_side, rad, d2, r2, rem, root, bitv, s;
    longint dx, dy, f, cur, nv;
    stamp_t res;
    eff_side = (brush_side > MAX_SIDE) ? MAX_SIDE : brush_side;
    rad = (brush_radius == 0) ? 1 : brush_radius;
    cur = v.height;
    nv = cur;
    res.changed = 1'b0;
    if (v.col < eff_side && v.row < eff_side) begin
      dx = longint'({v.col, 8'd0}) - longint'(ctr_col);
      dy = longint'({v.row, 8'd0}) - longint'(ctr_row);
      d2 = dx * dx + dy * dy;
      r2 = rad * rad;
      if (d2 <= r2) begin
        // integer square root of d2 / r2 in Q32, giving d / r in Q16
        rem = (d2 << 32) / r2;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > rem) bitv >>= 2;
        while (bitv != 0) begin
          if (rem >= root + bitv) begin
            rem = rem - (root + bitv);
            root = (root >> 1) + bitv;
          end else begin
            root = root >> 1;
          end
          bitv >>= 2;
        end
        // falloff: one minus smoothstep
        if (root >= 65536) begin
          f = 0;
        end else begin
          s = root * root * (196608 - 2 * root);
          f = 65536 - longint'(s >> 32);
        end
        res.changed = 1'b1;
        case (brush_mode)
          rhs_pkg::MODE_FLATTEN: nv = cur + round_q16((longint'(ctr_height) - cur) * f);
          rhs_pkg::MODE_CRATER:  nv = cur - round_q16(longint'(brush_strength) * f);
          rhs_pkg::MODE_HILL:    nv = cur + round_q16(longint'(brush_strength) * f);
          default:               nv = cur;
        endcase
        if (nv > H_MAX) nv = H_MAX;
        else if (nv < H_MIN) nv = H_MIN;
      end
    end
    res.height = nv[rhs_pkg::HGT_W-1:0];
    return res;
  endfunction

  // Drive one register write, called at a rising edge
  task automatic write_brush_reg(input logic [rhs_pkg::IDX_W-1:0] idx,
                                 input logic [rhs_pkg::CFG_W-1:0] data);
    wr_en    <= 1'b1;
    wr_index <= idx;
    wr_data  <= data;
    case (idx)
      rhs_pkg::REG_MODE:     brush_mode     = rhs_pkg::mode_t'(data[rhs_pkg::MODE_W-1:0]);
      rhs_pkg::REG_CCOL:     ctr_col        = data[rhs_pkg::POS_W-1:0];
      rhs_pkg::REG_CROW:     ctr_row        = data[rhs_pkg::POS_W-1:0];
      rhs_pkg::REG_RADIUS:   brush_radius   = data[rhs_pkg::RAD_W-1:0];
      rhs_pkg::REG_STRENGTH: brush_strength = data[rhs_pkg::STR_W-1:0];
      rhs_pkg::REG_CHEIGHT:  ctr_height     = data[rhs_pkg::HGT_W-1:0];
      rhs_pkg::REG_SIDE:     brush_side     = data[rhs_pkg::SIDE_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Load a full brush setting, plus one write to an index the block ignores
  task automatic set_brush(input rhs_pkg::mode_t m, input int cc, input int cr, input int rad,
                           input int str, input int ch, input int sd);
    write_brush_reg(rhs_pkg::REG_MODE, rhs_pkg::CFG_W'(m));
    write_brush_reg(rhs_pkg::REG_CCOL, rhs_pkg::CFG_W'(cc));
    write_brush_reg(rhs_pkg::REG_CROW, rhs_pkg::CFG_W'(cr));
    write_brush_reg(rhs_pkg::REG_RADIUS, rhs_pkg::CFG_W'(rad));
    write_brush_reg(rhs_pkg::REG_STRENGTH, rhs_pkg::CFG_W'(str));
    write_brush_reg(rhs_pkg::REG_CHEIGHT, rhs_pkg::CFG_W'(ch));
    write_brush_reg(rhs_pkg::REG_SIDE, rhs_pkg::CFG_W'(sd));
    write_brush_reg(REG_UNUSED, rhs_pkg::CFG_W'($urandom));
    wr_en <= 1'b0;
    settings_used++;
  endtask

  task automatic add_vertex(input int col, input int row, input int h);
    vertices_waiting.push_back('{col: rhs_pkg::COL_W'(col), row: rhs_pkg::COL_W'(row),
                                 height: rhs_pkg::HGT_W'(h)});
    pushed_total++;
  endtask

  // Wait until every queued vertex has been taken and answered
  task automatic settle();
    while (vertices_taken != pushed_total || heights_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Driver: bursts of vertices with random gaps
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        heights_due.push_back(stamp_vertex(vtx_on_port));
        vertices_taken++;
      end
      if (!(start && busy)) begin
        if (gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (vertices_waiting.size() > 0) begin
          vtx_on_port = vertices_waiting.pop_front();
          start          <= 1'b1;
          vertex_column  <= vtx_on_port.col;
          vertex_row     <= vtx_on_port.row;
          current_height <= vtx_on_port.height;
          burst_left--;
          if (burst_left <= 0) begin
            case ($urandom_range(0, 9))
              0: begin
                gap_left   = 0;
                burst_left = $urandom_range(100, 300);
              end
              1: begin
                gap_left   = $urandom_range(30, 70);
                burst_left = $urandom_range(1, 20);
              end
              default: begin
                gap_left   = $urandom_range(0, 4);
                burst_left = $urandom_range(1, 30);
              end
            endcase
          end
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each done word against the oldest expected height
  always @(posedge clk) begin
    stamp_t want;
    if (!rst && done) begin
      results_seen++;
      if (heights_due.size() == 0) begin
        $display("%0t unexpected result: expected none, actual height %0d changed %0b",
                 $time, new_height, changed);
        errors++;
      end else begin
        want = heights_due.pop_front();
        if (changed === 1'b1) inside_seen++;
        if (new_height !== want.height) begin
          $display("%0t new_height mismatch: expected %0d, actual %0d",
                   $time, want.height, new_height);
          errors++;
        end
        if (changed !== want.changed) begin
          $display("%0t changed mismatch: expected %0b, actual %0b",
                   $time, want.changed, changed);
          errors++;
        end
      end
    end
  end

  // Watchdog: end the run if no word moves for too long
  always @(posedge clk) begin
    if ((start && !busy) || done) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t watchdog: no progress for %0d cycles", $time, idle_cycles);
      $display("testbench: done, errors");
      $finish;
    end
  end

  initial begin
    int ph, k, span, cc, cr, rad, str, ch, sd, col, row, h;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Reset brush: centre, rim and just outside
    add_vertex(0, 0, int'(H_MAX));
    add_vertex(1, 0, int'(H_MIN));
    add_vertex(0, 1, 123);
    add_vertex(1, 1, -5);
    settle();

    // Widest hill: saturate high, partial weight, just beyond the radius
    set_brush(rhs_pkg::MODE_HILL, 512 << 8, 512 << 8, RAD_MAX, STR_MAX, 0, MAX_SIDE);
    add_vertex(512, 512, int'(H_MAX));
    add_vertex(512, 512, 0);
    add_vertex(256, 512, 77);
    add_vertex(400, 600, -300);
    add_vertex(1023, 1023, 9);
    settle();

    // Crater: saturate low and a partial dip
    set_brush(rhs_pkg::MODE_CRATER, 512 << 8, 512 << 8, RAD_MAX, STR_MAX, 0, MAX_SIDE);
    add_vertex(512, 512, int'(H_MIN));
    add_vertex(600, 450, 1000);
    settle();

    // Unused mode keeps the height but still flags the vertex
    set_brush(rhs_pkg::MODE_HOLD, 512 << 8, 512 << 8, RAD_MAX, STR_MAX, 0, MAX_SIDE);
    add_vertex(512, 512, 77);
    settle();

    // Zero radius acts as one; oversized grid clamps to the maximum side
    set_brush(rhs_pkg::MODE_FLATTEN, 5 << 8, 7 << 8, 0, 0, int'(H_MIN), 2047);
    add_vertex(5, 7, int'(H_MAX));
    add_vertex(6, 7, 0);
    add_vertex(1023, 0, 42);
    settle();

    // Empty grid puts every vertex outside
    set_brush(rhs_pkg::MODE_HILL, 0, 0, RAD_MAX, 1000, 0, 0);
    add_vertex(0, 0, 5);
    settle();

    // Single-vertex grid
    set_brush(rhs_pkg::MODE_HILL, 0, 0, RAD_MAX, 1000, 0, 1);
    add_vertex(0, 0, -1000);
    add_vertex(1, 0, -1000);
    settle();

    // Random brushes, most vertices aimed at the brush footprint
    for (ph = 0; ph < RANDOM_PHASES; ph++) begin
      case ($urandom_range(0, 5))
        0:       rad = RAD_MAX;
        1:       rad = $urandom_range(0, 4);
        2:       rad = $urandom_range(256, 4096);
        default: rad = $urandom_range(1, RAD_MAX);
      endcase
      cc = ($urandom_range(0, 3) == 0) ? ($urandom_range(0, 1023) << 8)
                                       : $urandom_range(0, 262143);
      cr = ($urandom_range(0, 3) == 0) ? ($urandom_range(0, 1023) << 8)
                                       : $urandom_range(0, 262143);
      if ($urandom_range(0, 3) == 0) str = $urandom_range(0, 1) ? STR_MAX : 0;
      else str = $urandom_range(0, STR_MAX);
      if ($urandom_range(0, 3) == 0) ch = $urandom_range(0, 1) ? int'(H_MAX) : int'(H_MIN);
      else ch = int'($urandom);
      case ($urandom_range(0, 7))
        0:       sd = 0;
        1:       sd = $urandom_range(MAX_SIDE + 1, 2047);
        2:       sd = $urandom_range(1, 64);
        default: sd = MAX_SIDE;
      endcase
      set_brush(rhs_pkg::mode_t'($urandom_range(0, 3)), cc, cr, rad, str, ch, sd);
      span = rad / 256 + 2;
      for (k = 0; k < PHASE_VERTICES; k++) begin
        if ($urandom_range(0, 4) != 0) begin
          col = cc / 256 + int'($urandom_range(0, 2 * span)) - span;
          row = cr / 256 + int'($urandom_range(0, 2 * span)) - span;
          if (col < 0) col = 0;
          if (col > 1023) col = 1023;
          if (row < 0) row = 0;
          if (row > 1023) row = 1023;
        end else begin
          col = $urandom_range(0, 1023);
          row = $urandom_range(0, 1023);
        end
        if ($urandom_range(0, 7) == 0) h = $urandom_range(0, 1) ? int'(H_MAX) : int'(H_MIN);
        else h = int'($urandom);
        add_vertex(col, row, h);
      end
      settle();
    end

    repeat (rhs_pkg::PIPE_DEPTH + 5) @(posedge clk);
    $display("stamped %0d vertices under %0d brush settings plus the reset brush",
             vertices_taken, settings_used);
    $display("%0d results checked, %0d of them inside the brush", results_seen, inside_seen);
    if (errors == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
